### hw/rtl/fcte_pkg.sv
// Shared types, constants and datapath command codes for the FAT16 cluster table engine.
`timescale 1ns / 1ps
`default_nettype none

package fcte_pkg;

  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int SECTOR_SHIFT      = 8;
  localparam int CFG_IDX_W         = 2;

  localparam logic [15:0] FIRST_DATA_CLUSTER = 16'h0002;
  localparam logic [15:0] END_OF_CHAIN_MIN   = 16'hFFF8;
  localparam logic [15:0] ENTRY_EOC          = 16'hFFFF;
  localparam logic [15:0] ENTRY_FREE         = 16'h0000;

  localparam logic [2:0] FN_READ  = 3'd0;
  localparam logic [2:0] FN_WRITE = 3'd1;
  localparam logic [2:0] FN_FIND  = 3'd2;
  localparam logic [2:0] FN_ALLOC = 3'd3;
  localparam logic [2:0] FN_FREE  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FAT_SECTORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC         = 2'd2;

  localparam logic [3:0] CMD_NOP        = 4'd0;
  localparam logic [3:0] CMD_CLEAR      = 4'd1;
  localparam logic [3:0] CMD_LOAD       = 4'd2;
  localparam logic [3:0] CMD_RD_ISSUE   = 4'd3;
  localparam logic [3:0] CMD_RD_DONE    = 4'd4;
  localparam logic [3:0] CMD_WRITE      = 4'd5;
  localparam logic [3:0] CMD_FIND_START = 4'd6;
  localparam logic [3:0] CMD_FIND_STEP  = 4'd7;
  localparam logic [3:0] CMD_FIND_HIT   = 4'd8;
  localparam logic [3:0] CMD_ALLOC      = 4'd9;
  localparam logic [3:0] CMD_FIND_MISS  = 4'd10;
  localparam logic [3:0] CMD_FREE_RD    = 4'd11;
  localparam logic [3:0] CMD_FREE_WB    = 4'd12;
  localparam logic [3:0] CMD_SET_ST     = 4'd13;
  localparam logic [3:0] CMD_PUSH       = 4'd14;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] cluster;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] entry_value;
    logic [31:0] sector_address;
    logic [16:0] freed_count;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic chain_end;
    logic too_long;
    logic pv;
    logic hit;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/fcte_dpath.sv
// Datapath: table memory, configuration registers, scan and chain registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module fcte_dpath
  import fcte_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  output out_item_t                 out_data
);

  localparam int          AW        = $clog2(TABLE_ENTRIES);
  localparam logic [16:0] TABLE_LIM = 17'(TABLE_ENTRIES);
  localparam logic [16:0] CLR_LAST  = 17'(TABLE_ENTRIES - 1);

  logic [15:0] mem [TABLE_ENTRIES];

  logic [4:0]  fsu_r;
  logic [31:0] dss_r;
  logic [7:0]  spc_r;

  logic [16:0]        scan_r, scan_nxt;
  logic               pv_r, pv_nxt;
  logic [15:0]        chk_addr_r, chk_addr_nxt;
  logic [15:0]        cur_r, cur_nxt;
  logic [15:0]        val_r, val_nxt;
  logic [16:0]        freed_r, freed_nxt;
  logic signed [25:0] prod_r, prod_nxt;
  logic [15:0]        ev_r, ev_nxt;
  logic [31:0]        sa_r, sa_nxt;
  logic [1:0]         st_r, st_nxt;
  out_item_t          out_r, out_nxt;
  logic [15:0]        rd_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_ra;
  logic [15:0]   mem_wd;

  logic [16:0]        lim_raw;
  logic [16:0]        lim;
  logic signed [16:0] cl_off;
  logic signed [8:0]  spc_s;

  assign lim_raw = 17'(fsu_r) << SECTOR_SHIFT;
  assign lim     = (lim_raw > TABLE_LIM) ? TABLE_LIM : lim_raw;
  assign cl_off  = $signed({1'b0, cur_r}) - 17'sd2;
  assign spc_s   = $signed({1'b0, spc_r});

  assign sts.clear_last = (scan_r == CLR_LAST);
  assign sts.in_range   = ({1'b0, cur_r} < lim);
  assign sts.chain_end  = (cur_r < FIRST_DATA_CLUSTER) || (cur_r >= END_OF_CHAIN_MIN);
  assign sts.too_long   = (freed_r >= lim);
  assign sts.pv         = pv_r;
  assign sts.hit        = (rd_data_r == ENTRY_FREE);

  assign out_data = out_r;

  always_comb begin
    scan_nxt     = scan_r;
    pv_nxt       = pv_r;
    chk_addr_nxt = chk_addr_r;
    cur_nxt      = cur_r;
    val_nxt      = val_r;
    freed_nxt    = freed_r;
    prod_nxt     = prod_r;
    ev_nxt       = ev_r;
    sa_nxt       = sa_r;
    st_nxt       = st_r;
    out_nxt      = out_r;
    mem_we       = 1'b0;
    mem_wa       = cur_r[AW-1:0];
    mem_wd       = ENTRY_FREE;
    mem_ra       = cur_r[AW-1:0];
    unique case (cmd.op)
      CMD_NOP: begin
      end
      CMD_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = scan_r[AW-1:0];
        scan_nxt = scan_r + 17'd1;
      end
      CMD_LOAD: begin
        cur_nxt   = in_data.cluster;
        val_nxt   = in_data.value;
        freed_nxt = '0;
        ev_nxt    = '0;
        sa_nxt    = '0;
        st_nxt    = ST_OK;
      end
      CMD_RD_ISSUE: begin
        prod_nxt = cl_off * spc_s;
      end
      CMD_RD_DONE: begin
        ev_nxt = rd_data_r;
        sa_nxt = dss_r + {{6{prod_r[25]}}, prod_r};
      end
      CMD_WRITE: begin
        mem_we = 1'b1;
        mem_wd = val_r;
      end
      CMD_FIND_START: begin
        mem_ra       = AW'(FIRST_DATA_CLUSTER);
        chk_addr_nxt = FIRST_DATA_CLUSTER;
        pv_nxt       = (17'(FIRST_DATA_CLUSTER) < lim);
        scan_nxt     = 17'(FIRST_DATA_CLUSTER) + 17'd1;
      end
      CMD_FIND_STEP: begin
        mem_ra       = scan_r[AW-1:0];
        chk_addr_nxt = scan_r[15:0];
        pv_nxt       = (scan_r < lim);
        scan_nxt     = scan_r + 17'd1;
      end
      CMD_FIND_HIT: begin
        ev_nxt = chk_addr_r;
      end
      CMD_ALLOC: begin
        mem_we = 1'b1;
        mem_wa = chk_addr_r[AW-1:0];
        mem_wd = ENTRY_EOC;
        ev_nxt = chk_addr_r;
      end
      CMD_FIND_MISS: begin
        ev_nxt = ENTRY_EOC;
        st_nxt = ST_NO_FREE;
      end
      CMD_FREE_RD: begin
      end
      CMD_FREE_WB: begin
        mem_we    = 1'b1;
        cur_nxt   = rd_data_r;
        freed_nxt = freed_r + 17'd1;
      end
      CMD_SET_ST: begin
        st_nxt = cmd.st;
      end
      CMD_PUSH: begin
        out_nxt.entry_value    = ev_r;
        out_nxt.sector_address = sa_r;
        out_nxt.freed_count    = freed_r;
        out_nxt.status         = st_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsu_r  <= 5'd16;
      dss_r  <= '0;
      spc_r  <= 8'd1;
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FAT_SECTORS: fsu_r <= cfg_wdata[4:0];
          CFG_DATA_START:  dss_r <= cfg_wdata;
          CFG_SPC:         spc_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pv_r       <= pv_nxt;
    chk_addr_r <= chk_addr_nxt;
    cur_r      <= cur_nxt;
    val_r      <= val_nxt;
    freed_r    <= freed_nxt;
    prod_r     <= prod_nxt;
    ev_r       <= ev_nxt;
    sa_r       <= sa_nxt;
    st_r       <= st_nxt;
    out_r      <= out_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/fcte_ctrl.sv
// Controller: operation sequencing state machine and output valid register.
`timescale 1ns / 1ps
`default_nettype none

module fcte_ctrl
  import fcte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_func,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_EXEC     = 3'd2;
  localparam logic [2:0] S_RD2      = 3'd3;
  localparam logic [2:0] S_FIND     = 3'd4;
  localparam logic [2:0] S_FREE_CHK = 3'd5;
  localparam logic [2:0] S_FREE_WB  = 3'd6;
  localparam logic [2:0] S_PUSH     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = CMD_NOP;
    cmd.st        = ST_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = CMD_CLEAR;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          func_nxt  = in_func;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (func_r)
          FN_READ: begin
            if (sts.in_range) begin
              cmd.op    = CMD_RD_ISSUE;
              state_nxt = S_RD2;
            end else begin
              cmd.op    = CMD_SET_ST;
              cmd.st    = ST_RANGE;
              state_nxt = S_PUSH;
            end
          end
          FN_WRITE: begin
            if (sts.in_range) begin
              cmd.op = CMD_WRITE;
            end else begin
              cmd.op = CMD_SET_ST;
              cmd.st = ST_RANGE;
            end
            state_nxt = S_PUSH;
          end
          FN_FIND, FN_ALLOC: begin
            cmd.op    = CMD_FIND_START;
            state_nxt = S_FIND;
          end
          FN_FREE: begin
            state_nxt = S_FREE_CHK;
          end
          default: begin
            state_nxt = S_PUSH;
          end
        endcase
      end
      S_RD2: begin
        cmd.op    = CMD_RD_DONE;
        state_nxt = S_PUSH;
      end
      S_FIND: begin
        priority if (!sts.pv) begin
          cmd.op    = CMD_FIND_MISS;
          state_nxt = S_PUSH;
        end else if (sts.hit) begin
          cmd.op    = (func_r == FN_ALLOC) ? CMD_ALLOC : CMD_FIND_HIT;
          state_nxt = S_PUSH;
        end else begin
          cmd.op = CMD_FIND_STEP;
        end
      end
      S_FREE_CHK: begin
        priority if (sts.chain_end) begin
          state_nxt = S_PUSH;
        end else if (!sts.in_range) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_RANGE;
          state_nxt = S_PUSH;
        end else if (sts.too_long) begin
          cmd.op    = CMD_SET_ST;
          cmd.st    = ST_LONG;
          state_nxt = S_PUSH;
        end else begin
          cmd.op    = CMD_FREE_RD;
          state_nxt = S_FREE_WB;
        end
      end
      S_FREE_WB: begin
        cmd.op    = CMD_FREE_WB;
        state_nxt = S_FREE_CHK;
      end
      S_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = CMD_PUSH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      func_r      <= FN_READ;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fat16_cluster_table_engine_top.sv
// Top level of the FAT16 cluster table engine: controller and datapath.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | in_data   (func, cluster, value)
//  out_    | output    | out_valid / out_stall | out_data  (entry_value, sector_address,
//          |           |                       |            freed_count, status)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// One transaction at a time, one table read port and one write port; cfg_ready is always high.
// Read checks the range, then reads the entry and forms the sector address; write checks the
// range and writes; find and allocate scan up from cluster 2 to a free entry or the limit;
// free chain reads and zeroes one entry at a time, following the chain to its end.
// After reset a clearing pass zeroes the table with in_stall high.
// A finished result waits in the output register while the next transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none

module fat16_cluster_table_engine_top
  import fcte_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fcte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fcte_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the FAT16 cluster table engine: directed probes, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import fcte_pkg::*;

  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int NEAR_CLUSTERS = 63;
  localparam int STALL_LIMIT = 40000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    in_item_t  op;
    logic      typed;
    out_item_t want;
  } probe_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]     cfg_wdata = '0;

  logic [15:0]     shadow_fat [DEF_TABLE_ENTRIES];
  logic [4:0]      sectors_used = 5'd16;
  logic [31:0]     data_start = 32'd0;
  logic [7:0]      sectors_per_clu = 8'd1;

  out_item_t       pending_results [$];
  out_item_t       head_item;
  probe_t          probe_q [$];
  int              mismatches = 0;
  int              ops_sent = 0;
  int              quiet_cycles = 0;
  bit              calm = 1'b0;

  fat16_cluster_table_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < DEF_TABLE_ENTRIES; i++) shadow_fat[i] = ENTRY_FREE;
  end

  function automatic int unsigned active_entries();
    int unsigned n;
    n = int'(sectors_used) << SECTOR_SHIFT;
    if (n > DEF_TABLE_ENTRIES) n = DEF_TABLE_ENTRIES;
    return n;
  endfunction

  function automatic logic [15:0] lowest_free(input int unsigned lim);
    for (int unsigned c = FIRST_DATA_CLUSTER; c < lim; c++) begin
      if (shadow_fat[c] == ENTRY_FREE) return 16'(c);
    end
    return ENTRY_EOC;
  endfunction

  function automatic out_item_t table_op_result(input in_item_t op);
    out_item_t   r;
    int unsigned lim;
    int unsigned cur;
    int unsigned nxt;
    int unsigned n;
    r = '0;
    n = 0;
    lim = active_entries();
    case (op.func)
      FN_READ: begin
        if (op.cluster >= lim) begin
          r.status = ST_RANGE;
        end else begin
          r.entry_value = shadow_fat[op.cluster];
          r.sector_address = data_start + (32'(op.cluster) - 32'(FIRST_DATA_CLUSTER))
                             * 32'(sectors_per_clu);
        end
      end
      FN_WRITE: begin
        if (op.cluster >= lim) r.status = ST_RANGE;
        else shadow_fat[op.cluster] = op.value;
      end
      FN_FIND, FN_ALLOC: begin
        r.entry_value = lowest_free(lim);
        if (r.entry_value == ENTRY_EOC) r.status = ST_NO_FREE;
        else if (op.func == FN_ALLOC) shadow_fat[r.entry_value] = ENTRY_EOC;
      end
      FN_FREE: begin
        cur = op.cluster;
        while (cur >= FIRST_DATA_CLUSTER && cur < END_OF_CHAIN_MIN) begin
          if (cur >= lim) begin
            r.status = ST_RANGE;
            break;
          end
          if (n >= lim) begin
            r.status = ST_LONG;
            break;
          end
          nxt = shadow_fat[cur];
          shadow_fat[cur] = ENTRY_FREE;
          n++;
          cur = nxt;
        end
        r.freed_count = 17'(n);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk_op(input logic [2:0] f, input logic [15:0] c,
                                     input logic [15:0] v);
    in_item_t op;
    op.func = f;
    op.cluster = c;
    op.value = v;
    return op;
  endfunction

  function automatic probe_t probe(input logic [2:0] f, input logic [15:0] c,
                                  input logic [15:0] v, input logic t,
                                  input logic [15:0] ev, input logic [31:0] sa,
                                  input logic [16:0] fc, input logic [1:0] st);
    probe_t p;
    p.op = mk_op(f, c, v);
    p.typed = t;
    p.want.entry_value = ev;
    p.want.sector_address = sa;
    p.want.freed_count = fc;
    p.want.status = st;
    return p;
  endfunction

  function automatic in_item_t noise_op();
    logic [2:0]  f;
    logic [15:0] c;
    logic [15:0] v;
    int unsigned lim;
    lim = active_entries();
    case ($urandom_range(0, 9))
      0, 1, 2: f = FN_READ;
      3, 4:    f = FN_WRITE;
      5:       f = FN_FIND;
      6:       f = FN_ALLOC;
      7, 8:    f = FN_FREE;
      default: f = 3'($urandom_range(FN_SPARE_A, FN_SPARE_C));
    endcase
    case ($urandom_range(0, 9))
      0:       c = 16'($urandom);
      1:       c = 16'(lim + $urandom_range(0, 2) - 1);
      2:       c = 16'($urandom_range(0, 1));
      default: c = 16'($urandom_range(0, NEAR_CLUSTERS));
    endcase
    case ($urandom_range(0, 9))
      0:       v = 16'($urandom);
      1:       v = 16'($urandom_range(END_OF_CHAIN_MIN, ENTRY_EOC));
      2:       v = ENTRY_FREE;
      3:       v = 16'(lim + $urandom_range(0, 2) - 1);
      default: v = 16'($urandom_range(FIRST_DATA_CLUSTER, NEAR_CLUSTERS));
    endcase
    return mk_op(f, c, v);
  endfunction

  task automatic send_op(input in_item_t op, input logic typed, input out_item_t want,
                         output out_item_t got);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    got = table_op_result(op);
    pending_results.push_back(typed ? want : got);
    ops_sent++;
  endtask

  task automatic send_plain(input in_item_t op, output out_item_t got);
    send_op(op, 1'b0, '0, got);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_FAT_SECTORS: sectors_used = data[4:0];
      CFG_DATA_START:  data_start = data;
      CFG_SPC:         sectors_per_clu = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [4:0] fat, input logic [31:0] start,
                            input logic [7:0] spc);
    cfg_write(CFG_FAT_SECTORS, {($urandom_range(0, 1) ? 27'($urandom) : 27'd0), fat});
    cfg_write(CFG_DATA_START, start);
    cfg_write(CFG_SPC, {($urandom_range(0, 1) ? 24'($urandom) : 24'd0), spc});
    cfg_write(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // allocate, link, read back and usually free one chain
  task automatic chain_run();
    logic [15:0] links [$];
    out_item_t   r;
    int          k;
    k = $urandom_range(1, 6);
    repeat (k) begin
      send_plain(mk_op(FN_ALLOC, 16'($urandom), 16'($urandom)), r);
      if (r.status == ST_OK) links.push_back(r.entry_value);
    end
    if (links.size() == 0) return;
    for (int i = 0; i + 1 < links.size(); i++)
      send_plain(mk_op(FN_WRITE, links[i], links[i + 1]), r);
    if ($urandom_range(0, 1))
      send_plain(mk_op(FN_WRITE, links[links.size() - 1],
                       16'($urandom_range(END_OF_CHAIN_MIN, ENTRY_EOC))), r);
    repeat ($urandom_range(1, 2))
      send_plain(mk_op(FN_READ, links[$urandom_range(0, links.size() - 1)],
                       16'($urandom)), r);
    k = $urandom_range(0, 19);
    if (k < 14)
      send_plain(mk_op(FN_FREE, links[0], 16'($urandom)), r);
    else if (k < 17)
      send_plain(mk_op(FN_FREE, links[$urandom_range(0, links.size() - 1)],
                       16'($urandom)), r);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 30);
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result: ev=%h sa=%h fc=%h st=%0d", out_data.entry_value,
                   out_data.sector_address, out_data.freed_count, out_data.status);
        mismatches++;
      end else begin
        head_item = pending_results.pop_front();
        if (out_data.entry_value !== head_item.entry_value ||
            out_data.sector_address !== head_item.sector_address ||
            out_data.freed_count !== head_item.freed_count ||
            out_data.status !== head_item.status) begin
          if (mismatches < REPORT_MAX)
            $display("mismatch: want ev=%h sa=%h fc=%h st=%0d, got ev=%h sa=%h fc=%h st=%0d",
                     head_item.entry_value, head_item.sector_address,
                     head_item.freed_count, head_item.status,
                     out_data.entry_value, out_data.sector_address,
                     out_data.freed_count, out_data.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) || cfg_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[fat16_cluster_table_engine_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_item_t got;
    int        phase_end;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    probe_q.push_back(probe(FN_READ, 16'd2, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_READ, 16'd0, 16'hFFFF, 1, 16'd0, 32'hFFFF_FFFE, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_READ, 16'd1, 16'd0, 1, 16'd0, 32'hFFFF_FFFF, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_READ, 16'd4096, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_RANGE));
    probe_q.push_back(probe(FN_READ, 16'hFFFF, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_RANGE));
    probe_q.push_back(probe(FN_WRITE, 16'hFFFF, 16'hFFFF, 1, 16'd0, 32'd0, 17'd0, ST_RANGE));
    probe_q.push_back(probe(FN_FIND, 16'd0, 16'd0, 1, 16'd2, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_ALLOC, 16'd0, 16'd0, 1, 16'd2, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_ALLOC, 16'hFFFF, 16'hFFFF, 1, 16'd3, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_WRITE, 16'd2, 16'd3, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_WRITE, 16'd3, 16'd4, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_WRITE, 16'd4, 16'hFFF8, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_READ, 16'd3, 16'd0, 1, 16'd4, 32'd1, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'd2, 16'd0, 1, 16'd0, 32'd0, 17'd3, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'hFFFF, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'd1, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'd0, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'd4096, 16'd0, 1, 16'd0, 32'd0, 17'd0, ST_RANGE));
    probe_q.push_back(probe(FN_WRITE, 16'd10, 16'd4096, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'd10, 16'd0, 1, 16'd0, 32'd0, 17'd1, ST_RANGE));
    probe_q.push_back(probe(FN_WRITE, 16'd4095, 16'hFFF7, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_READ, 16'd4095, 16'd0, 1, 16'hFFF7, 32'd4093, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_FREE, 16'd4095, 16'd0, 1, 16'd0, 32'd0, 17'd1, ST_RANGE));
    probe_q.push_back(probe(FN_SPARE_A, 16'hFFFF, 16'hFFFF, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_SPARE_B, 16'hFFFF, 16'hFFFF, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_SPARE_C, 16'hFFFF, 16'hFFFF, 1, 16'd0, 32'd0, 17'd0, ST_OK));
    probe_q.push_back(probe(FN_ALLOC, 16'd0, 16'd0, 0, 16'd0, 32'd0, 17'd0, ST_OK));
    foreach (probe_q[i]) send_op(probe_q[i].op, probe_q[i].typed, probe_q[i].want, got);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: set_config(5'd1, 32'hFFFF_FFFF, 8'd128);
        1: set_config(5'd0, $urandom, 8'd0);
        2: set_config(5'd31, 32'd0, 8'd255);
        3: set_config(5'd16, $urandom, 8'($urandom_range(1, 128)));
        4: set_config(5'($urandom_range(1, 16)), $urandom, 8'($urandom));
        5: set_config(5'($urandom_range(17, 31)), $urandom, 8'($urandom_range(1, 128)));
        6: set_config(5'd2, 32'd0, 8'd1);
        default: set_config(5'd16, 32'hFFFF_FFF0, 8'd128);
      endcase
      calm = (ph == 3);
      if (ph == 0) begin
        repeat (256) send_plain(mk_op(FN_ALLOC, 16'($urandom), 16'($urandom)), got);
        send_plain(mk_op(FN_FIND, 16'($urandom), 16'($urandom)), got);
      end
      phase_end = ops_sent + ((ph == 1) ? 60 : 150);
      while (ops_sent < phase_end) begin
        if ($urandom_range(0, 99) < 65) chain_run();
        else send_plain(noise_op(), got);
      end
    end

    drain();
    calm = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[fat16_cluster_table_engine_top] OK");
    end else begin
      $display("[fat16_cluster_table_engine_top] ERROR");
    end
    $finish;
  end

endmodule
